>>> sv/rational_arith_unit_defines.svh
// assertion macros shared by the rational arithmetic unit
// no dependencies; included by files that carry concurrent assertions
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// same-cycle implication under an active-low reset
`define RAU_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rational_arith_unit assertion failed");

// next-cycle implication under an active-low reset
`define RAU_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rational_arith_unit assertion failed");

`endif

>>> sv/rau_pkg.sv
// types and codes of the rational arithmetic unit
// no dependencies; used by rational_arith_unit
`default_nettype none

package rau_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_GT  = 3'd5,
    OP_LT  = 3'd6
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MST,
    S_MUL,
    S_COMB,
    S_GCD,
    S_GSH,
    S_DMS,
    S_DMW,
    S_DDS,
    S_DDW,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               compare_true;
    logic               divide_by_zero;
    logic               overflow;
  } out_t;

endpackage

`default_nettype wire

>>> sv/rau_mul.sv
// sequential shift-add multiplier, one multiplier bit per cycle
// no dependencies; instantiated by rational_arith_unit
`default_nettype none

module rau_mul #(
  parameter int W = 32
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  input  wire logic [W-1:0]   x_i,
  input  wire logic [W-1:0]   y_i,
  output logic                done_o,
  output logic [2*W-1:0]      prod_o
);

  localparam int PW = 2 * W;
  localparam int CW = $clog2(W) + 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] mcand_q, mcand_d;
  logic [W-1:0]  mplier_q, mplier_d;
  logic [PW-1:0] acc_q, acc_d;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    if (start_i) begin
      busy_d   = 1'b1;
      cnt_d    = CW'(W);
      mcand_d  = PW'(x_i);
      mplier_d = y_i;
      acc_d    = '0;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

>>> sv/rau_div.sv
// restoring unsigned divider, one quotient bit per cycle
// no dependencies; instantiated by rational_arith_unit
`default_nettype none

module rau_div #(
  parameter int PW = 64
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [PW-1:0] dividend_i,
  input  wire logic [PW-1:0] divisor_i,
  output logic               done_o,
  output logic [PW-1:0]      quo_o
);

  localparam int CW = $clog2(PW) + 1;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [PW-1:0] quo_q, quo_d;
  logic [PW-1:0] dsr_q, dsr_d;
  logic [PW:0]   trial;
  logic          fits;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    trial  = {rem_q, quo_q[PW-1]};
    fits   = trial >= {1'b0, dsr_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(PW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // partial remainder stays below the divisor, so PW bits hold it
      rem_d = fits ? PW'(trial - {1'b0, dsr_q}) : PW'(trial);
      quo_d = {quo_q[PW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

>>> sv/rational_arith_unit.sv
// top level of the rational arithmetic unit: sequencer, gcd datapath, result register
// depends on rau_pkg, rau_mul, rau_div and rational_arith_unit_defines.svh
`default_nettype none
`include "rational_arith_unit_defines.svh"

// A transaction is accepted on a clock edge with start high and busy low. The
// block then works alone on it and, but for the early answers below, keeps
// busy high until the result is ready. The result is shown on res_o for
// exactly one cycle, marked by res_valid_o; the receiver cannot stall it, so
// it must take it in that cycle. Busy drops in the strobe cycle, so the next
// start may coincide with the strobe. Divide by a zero fraction and the
// undefined code 7 answer early, in the cycle after acceptance. Otherwise the
// work runs through one shared shift-add multiplier (two or three products),
// a binary gcd loop on 2W-bit values with W = VALUE_WIDTH (one shift or
// subtract a cycle, then a restore shift per common factor of two), and one
// shared restoring divider used twice to divide numerator and denominator by
// the gcd. Compares end after the products; arithmetic is dominated by the
// gcd loop and the two divider passes.
module rational_arith_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rau_pkg::in_t  in_i,
  output logic               res_valid_o,
  output rau_pkg::out_t      res_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int PW = 2 * VALUE_WIDTH;
  localparam int KW = $clog2(PW) + 1;
  localparam logic [PW-1:0] Limit = PW'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

  // sequencer state and operands of the current transaction
  rau_pkg::state_e state_q, state_d;
  rau_pkg::op_e    op_q, op_d;
  logic            a_neg_q, a_neg_d, b_neg_q, b_neg_d;
  logic [W-1:0]    a_mag_q, a_mag_d, a_den_q, a_den_d;
  logic [W-1:0]    b_mag_q, b_mag_d, b_den_q, b_den_d;
  logic [1:0]      step_q, step_d;

  // wide datapath registers
  logic [PW-1:0]   p0_q, p0_d, p1_q, p1_d;
  logic [PW-1:0]   mag_q, mag_d, den_q, den_d;
  logic            neg_q, neg_d;
  logic [PW-1:0]   u_q, u_d, v_q, v_d, g_q, g_d;
  logic [KW-1:0]   k_q, k_d;

  rau_pkg::out_t   res_q, res_d;
  logic            res_valid_q, res_valid_d;

  // input decode: sign and magnitude of the low W bits
  logic [W-1:0] an_w, ad_w, bn_w, bd_w;
  logic [W-1:0] an_m, ad_m, bn_m, bd_m;
  logic         an_s, ad_s, bn_s, bd_s;

  always_comb begin
    an_w = in_i.a_num[W-1:0];
    ad_w = in_i.a_den[W-1:0];
    bn_w = in_i.b_num[W-1:0];
    bd_w = in_i.b_den[W-1:0];
    an_s = an_w[W-1];
    ad_s = ad_w[W-1];
    bn_s = bn_w[W-1];
    bd_s = bd_w[W-1];
    an_m = an_s ? (~an_w + 1'b1) : an_w;
    bn_m = bn_s ? (~bn_w + 1'b1) : bn_w;
    // zero denominator reads as one
    ad_m = (ad_w == '0) ? W'(1) : (ad_s ? (~ad_w + 1'b1) : ad_w);
    bd_m = (bd_w == '0) ? W'(1) : (bd_s ? (~bd_w + 1'b1) : bd_w);
  end

  // shared multiplier and divider
  logic          mul_start, mul_done;
  logic [W-1:0]  mul_x, mul_y;
  logic [PW-1:0] mul_prod;
  logic          div_start, div_done;
  logic [PW-1:0] div_a, div_quo;

  rau_mul #(.W(W)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  rau_div #(.PW(PW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (g_q),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // product schedule: p0 = a_mag*b_den (a_mag*b_mag for multiply),
  // p1 = b_mag*a_den, den = a_den*b_den (a_den*b_mag for divide)
  always_comb begin
    case (step_q)
      2'd0: begin
        mul_x = a_mag_q;
        mul_y = (op_q == rau_pkg::OP_MUL) ? b_mag_q : b_den_q;
      end
      2'd1: begin
        mul_x = b_mag_q;
        mul_y = a_den_q;
      end
      default: begin
        mul_x = a_den_q;
        mul_y = (op_q == rau_pkg::OP_DIV) ? b_mag_q : b_den_q;
      end
    endcase
  end

  // signed sum of the cross products, shared by add, subtract and compares
  logic          sb, sum_s, is_cmp, is_addsub;
  logic [PW-1:0] sum_m, red_mag;
  logic          red_neg;
  logic [31:0]   m32;

  always_comb begin
    is_cmp    = (op_q == rau_pkg::OP_EQ) || (op_q == rau_pkg::OP_GT) ||
                (op_q == rau_pkg::OP_LT);
    is_addsub = (op_q == rau_pkg::OP_ADD) || (op_q == rau_pkg::OP_SUB);
    sb        = (op_q == rau_pkg::OP_ADD) ? b_neg_q : !b_neg_q;
    if (a_neg_q == sb) begin
      sum_m = p0_q + p1_q;
      sum_s = a_neg_q;
    end else if (p0_q >= p1_q) begin
      sum_m = p0_q - p1_q;
      sum_s = a_neg_q;
    end else begin
      sum_m = p1_q - p0_q;
      sum_s = sb;
    end
    if (sum_m == '0) begin
      sum_s = 1'b0;
    end
    red_mag = is_addsub ? sum_m : p0_q;
    red_neg = is_addsub ? sum_s : ((p0_q != '0) && (a_neg_q != b_neg_q));
    m32     = 32'(mag_q[W-1:0]);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    a_neg_d     = a_neg_q;
    b_neg_d     = b_neg_q;
    a_mag_d     = a_mag_q;
    a_den_d     = a_den_q;
    b_mag_d     = b_mag_q;
    b_den_d     = b_den_q;
    step_d      = step_q;
    p0_d        = p0_q;
    p1_d        = p1_q;
    mag_d       = mag_q;
    den_d       = den_q;
    neg_d       = neg_q;
    u_d         = u_q;
    v_d         = v_q;
    g_d         = g_q;
    k_d         = k_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    div_a       = mag_q;

    case (state_q)
      rau_pkg::S_IDLE: begin
        if (start) begin
          a_mag_d = an_m;
          a_den_d = ad_m;
          b_mag_d = bn_m;
          b_den_d = bd_m;
          a_neg_d = (an_m != '0) && (an_s != ((ad_w != '0) && ad_s));
          b_neg_d = (bn_m != '0) && (bn_s != ((bd_w != '0) && bd_s));
          step_d  = 2'd0;
          res_d   = '{res_num: '0, res_den: 31'd1, compare_true: 1'b0,
                      divide_by_zero: 1'b0, overflow: 1'b0};
          if (in_i.operation == 3'(rau_pkg::OP_DIV) && bn_m == '0) begin
            // divide by a zero fraction
            res_d.divide_by_zero = 1'b1;
            res_valid_d          = 1'b1;
          end else if (in_i.operation > 3'(rau_pkg::OP_LT)) begin
            // undefined code answers 0/1 with no flags
            res_valid_d = 1'b1;
          end else begin
            op_d    = rau_pkg::op_e'(in_i.operation);
            state_d = rau_pkg::S_MST;
          end
        end
      end
      rau_pkg::S_MST: begin
        mul_start = 1'b1;
        state_d   = rau_pkg::S_MUL;
      end
      rau_pkg::S_MUL: begin
        if (mul_done) begin
          state_d = rau_pkg::S_MST;
          case (step_q)
            2'd0: begin
              p0_d   = mul_prod;
              step_d = ((op_q == rau_pkg::OP_MUL) || (op_q == rau_pkg::OP_DIV)) ? 2'd2 : 2'd1;
            end
            2'd1: begin
              p1_d   = mul_prod;
              step_d = 2'd2;
              if (is_cmp) begin
                state_d = rau_pkg::S_COMB;
              end
            end
            default: begin
              den_d   = mul_prod;
              state_d = rau_pkg::S_COMB;
            end
          endcase
        end
      end
      rau_pkg::S_COMB: begin
        if (is_cmp) begin
          case (op_q)
            rau_pkg::OP_EQ: res_d.compare_true = (sum_m == '0);
            rau_pkg::OP_GT: res_d.compare_true = (sum_m != '0) && !sum_s;
            default:        res_d.compare_true = (sum_m != '0) && sum_s;
          endcase
          res_valid_d = 1'b1;
          state_d     = rau_pkg::S_IDLE;
        end else begin
          mag_d   = red_mag;
          neg_d   = red_neg;
          u_d     = red_mag;
          v_d     = den_q;
          k_d     = '0;
          state_d = rau_pkg::S_GCD;
        end
      end
      rau_pkg::S_GCD: begin
        // binary gcd: one shift or one subtract per cycle
        if (u_q == '0 || v_q == '0) begin
          g_d     = (u_q == '0) ? v_q : u_q;
          state_d = rau_pkg::S_GSH;
        end else if (!u_q[0] && !v_q[0]) begin
          u_d = u_q >> 1;
          v_d = v_q >> 1;
          k_d = k_q + 1'b1;
        end else if (!u_q[0]) begin
          u_d = u_q >> 1;
        end else if (!v_q[0]) begin
          v_d = v_q >> 1;
        end else if (u_q >= v_q) begin
          u_d = u_q - v_q;
        end else begin
          v_d = v_q - u_q;
        end
      end
      rau_pkg::S_GSH: begin
        // restore the common factors of two
        if (k_q == '0) begin
          state_d = rau_pkg::S_DMS;
        end else begin
          g_d = g_q << 1;
          k_d = k_q - 1'b1;
        end
      end
      rau_pkg::S_DMS: begin
        div_start = 1'b1;
        state_d   = rau_pkg::S_DMW;
      end
      rau_pkg::S_DMW: begin
        if (div_done) begin
          mag_d   = div_quo;
          state_d = rau_pkg::S_DDS;
        end
      end
      rau_pkg::S_DDS: begin
        div_a     = den_q;
        div_start = 1'b1;
        state_d   = rau_pkg::S_DDW;
      end
      rau_pkg::S_DDW: begin
        if (div_done) begin
          den_d   = div_quo;
          state_d = rau_pkg::S_FIN;
        end
      end
      rau_pkg::S_FIN: begin
        if (den_q > Limit || mag_q > (neg_q ? (Limit + 1'b1) : Limit)) begin
          res_d.overflow = 1'b1;
        end else begin
          res_d.res_num = $signed(neg_q ? (32'd0 - m32) : m32);
          res_d.res_den = 31'(den_q[W-1:0]);
        end
        res_valid_d = 1'b1;
        state_d     = rau_pkg::S_IDLE;
      end
      default: begin
        state_d = rau_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rau_pkg::S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    a_neg_q <= a_neg_d;
    b_neg_q <= b_neg_d;
    a_mag_q <= a_mag_d;
    a_den_q <= a_den_d;
    b_mag_q <= b_mag_d;
    b_den_q <= b_den_d;
    step_q  <= step_d;
    p0_q    <= p0_d;
    p1_q    <= p1_d;
    mag_q   <= mag_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    u_q     <= u_d;
    v_q     <= v_d;
    g_q     <= g_d;
    k_q     <= k_d;
    res_q   <= res_d;
  end

  assign busy        = (state_q != rau_pkg::S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `RAU_ASSERT_IMP(a_strobe_when_idle, clk_i, rst_ni, res_valid_o, !busy)
  `RAU_ASSERT_IMP(a_den_positive, clk_i, rst_ni, res_valid_o, res_o.res_den != '0)
  `RAU_ASSERT_IMP(a_forced_zero, clk_i, rst_ni, res_valid_o && (res_o.divide_by_zero || res_o.overflow), res_o.res_num == '0 && res_o.res_den == 31'd1)
  `RAU_ASSERT_IMP(a_flags_exclusive, clk_i, rst_ni, res_valid_o, !(res_o.compare_true && (res_o.divide_by_zero || res_o.overflow)))

endmodule

`default_nettype wire
